// ===== sv/edge_traffic_map_defines.svh =====
// Assertion macros shared by the edge traffic map RTL.
`ifndef EDGE_TRAFFIC_MAP_DEFINES_SVH
`define EDGE_TRAFFIC_MAP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define ETM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("edge_traffic_map assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define ETM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("edge_traffic_map assertion failed");

`endif

// ===== sv/etm_pkg.sv =====
// Package for the edge traffic map: constants, codes and state types.
`timescale 1ns / 1ps

package etm_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_DEGREE_DEF   = 4;

    // Field widths.
    localparam int TW  = 10;   // vertex id / stored target
    localparam int CW  = 32;   // Q16.16 count
    localparam int WW  = 16;   // Q8.8 weight
    localparam int DFW = 17;   // decay factor
    localparam int CIW = 4;    // config index

    localparam logic [WW-1:0]  ONE_Q88  = 16'd256;
    localparam logic [16:0]    COST_INF = 17'h1FFFF;
    localparam logic [DFW-1:0] DECAY_NONE = 17'h10000;

    // Commands.
    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_OPEN  = 3'd1,
        CMD_EVENT = 3'd2,
        CMD_CLOSE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_CLEAR = 3'd5
    } cmd_t;

    // Register indexes.
    typedef enum logic [CIW-1:0] {
        REG_LB    = 4'd0,
        REG_UB    = 4'd1,
        REG_DECAY = 4'd2,
        REG_AC    = 4'd3,
        REG_AB    = 4'd4,
        REG_AW    = 4'd5,
        REG_PEN   = 4'd6,
        REG_ADD   = 4'd7
    } reg_idx_t;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'h0001,
        ST_FILL   = 14'h0002,
        ST_LK_RD  = 14'h0004,
        ST_LK_CHK = 14'h0008,
        ST_RMW_RD = 14'h0010,
        ST_RMW_WR = 14'h0020,
        ST_WS_RD  = 14'h0040,
        ST_WS_CHK = 14'h0080,
        ST_SW_RD  = 14'h0100,
        ST_SW_EX  = 14'h0200,
        ST_DLD    = 14'h0400,
        ST_DIV    = 14'h0800,
        ST_SW_WR  = 14'h1000,
        ST_DONE   = 14'h2000
    } state_t;

    // What a finished lookup feeds.
    typedef enum logic [1:0] {
        PH_READ = 2'd0,
        PH_FWD  = 2'd1,
        PH_REV  = 2'd2,
        PH_WAIT = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        PASS_MAX    = 2'd0,
        PASS_DECAY  = 2'd1,
        PASS_WEIGHT = 2'd2
    } pass_t;

    typedef enum logic [1:0] {
        FILL_INIT  = 2'd0,
        FILL_CLEAR = 2'd1,
        FILL_FLAT  = 2'd2
    } fill_t;

    // Saturating add of a Q8.8 increment to a Q16.16 count.
    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] c,
                                              input logic [WW-1:0] d);
        logic [CW:0] s;
        s = {1'b0, c} + {9'd0, d, 8'd0};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

endpackage

// ===== sv/etm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps

module etm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/edge_traffic_map.sv =====
// Edge traffic map top level: command sequencer over the edge memories.
`timescale 1ns / 1ps
`include "edge_traffic_map_defines.svh"

// Per-edge traffic counter. State sits in three RAMs (neighbor slots, counts,
// weights) addressed {vertex, slot}. Read edge and a move event probe up to
// MAX_DEGREE slots (a move with contraflow probes twice); a wait scans every
// out-slot and does a lookup for each valid one. Open batch with decay walks
// the count RAM; close batch walks it twice, first to find the maximum, then
// to write the weights (a divide by that maximum, 16 quotient bits, one a
// cycle; ub if ub <= lb), or flat weights when the maximum is zero. Clear
// counts writes one entry a cycle. After reset a clearing pass over all
// 2**(VAW+SW) entries (4096 by default) runs before the first command is
// taken; config writes are always taken.
module edge_traffic_map #(
    parameter int MAX_VERTICES = etm_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = etm_pkg::MAX_DEGREE_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // config writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [etm_pkg::CIW-1:0]   cfg_addr,
    input  logic [etm_pkg::DFW-1:0]   cfg_data,
    // command beats
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_cmd,
    input  logic [etm_pkg::TW-1:0]    s_from_vertex,
    input  logic [etm_pkg::TW-1:0]    s_to_vertex,
    input  logic [1:0]                s_neighbor_slot,
    input  logic                      s_event_blocked,
    input  logic                      s_at_goal,
    // result beats
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_edge_exists,
    output logic [etm_pkg::CW-1:0]    m_traffic_cnt,
    output logic [etm_pkg::WW-1:0]    m_edge_weight,
    output logic [16:0]               m_path_cost,
    output logic [etm_pkg::CW-1:0]    m_peak_cnt
);

    localparam int TW  = etm_pkg::TW;
    localparam int CW  = etm_pkg::CW;
    localparam int WW  = etm_pkg::WW;
    localparam int DFW = etm_pkg::DFW;
    localparam int VAW = ($clog2(MAX_VERTICES) > TW) ? TW : $clog2(MAX_VERTICES);
    localparam int SW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int AW  = VAW + SW;
    localparam int DEPTH = 1 << AW;
    localparam int NBW = TW + 1;
    localparam int PW  = CW + DFW;
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_DEGREE - 1);

    etm_pkg::state_t state_reg, state_next;
    etm_pkg::phase_t phase_reg, phase_next;
    etm_pkg::pass_t  pass_reg, pass_next;
    etm_pkg::fill_t  fill_reg, fill_next;

    // config
    logic [WW-1:0]  lb_reg, ub_reg, ac_reg, ab_reg, aw_reg, pen_reg;
    logic [DFW-1:0] decay_reg;
    logic           add_reg;

    // latched command
    logic [TW-1:0] from_reg, from_next, to_reg, to_next;

    // lookup and walk control
    logic [TW-1:0]  lk_v_reg, lk_v_next, lk_t_reg, lk_t_next;
    logic           lk_ok_reg, lk_ok_next;
    logic [SW-1:0]  lk_s_reg, lk_s_next, ws_reg, ws_next;
    logic [AW-1:0]  idx_reg, idx_next, sw_reg, sw_next;
    logic [WW-1:0]  delta_reg, delta_next;
    logic [CW-1:0]  max_reg, max_next, last_max_reg, last_max_next;
    logic [PW-1:0]  prod_reg, prod_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic [15:0]    num_reg, num_next, quo_reg, quo_next;
    logic [3:0]     dcnt_reg, dcnt_next;

    // pending result and output beat
    logic           res_ex_reg, res_ex_next;
    logic [CW-1:0]  res_cnt_reg, res_cnt_next;
    logic [WW-1:0]  res_wt_reg, res_wt_next;
    logic [16:0]    res_cost_reg, res_cost_next;
    logic           mv_reg, mv_next;
    logic           o_ex_reg, o_ex_next;
    logic [CW-1:0]  o_cnt_reg, o_cnt_next, o_max_reg, o_max_next;
    logic [WW-1:0]  o_wt_reg, o_wt_next;
    logic [16:0]    o_cost_reg, o_cost_next;

    // memory ports
    logic           nb_we, cnt_we, wt_we;
    logic [AW-1:0]  waddr, nb_raddr, c_raddr;
    logic [NBW-1:0] nb_wdata, nb_rdata;
    logic [CW-1:0]  cnt_wdata, cnt_rdata;
    logic [WW-1:0]  wt_wdata, wt_rdata;

    logic [WW-1:0]  flat_w, lb_floor;
    logic [CW:0]    rem_sh;
    logic           hit, sw_last;

    etm_ram #(.WIDTH(NBW), .DEPTH(DEPTH)) u_nb_ram (
        .aclk(aclk), .we(nb_we), .waddr(waddr), .wdata(nb_wdata),
        .raddr(nb_raddr), .rdata(nb_rdata)
    );
    etm_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cnt_ram (
        .aclk(aclk), .we(cnt_we), .waddr(waddr), .wdata(cnt_wdata),
        .raddr(c_raddr), .rdata(cnt_rdata)
    );
    etm_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_wt_ram (
        .aclk(aclk), .we(wt_we), .waddr(waddr), .wdata(wt_wdata),
        .raddr(c_raddr), .rdata(wt_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == etm_pkg::ST_IDLE);

    assign m_valid       = mv_reg;
    assign m_edge_exists = o_ex_reg;
    assign m_traffic_cnt = o_cnt_reg;
    assign m_edge_weight = o_wt_reg;
    assign m_path_cost   = o_cost_reg;
    assign m_peak_cnt    = o_max_reg;

    // flat weight: min(max(1.0, lb), ub)
    assign lb_floor = (lb_reg > etm_pkg::ONE_Q88) ? lb_reg : etm_pkg::ONE_Q88;
    assign flat_w   = (lb_floor > ub_reg) ? ub_reg : lb_floor;

    assign hit     = lk_ok_reg && nb_rdata[TW] && (nb_rdata[TW-1:0] == lk_t_reg);
    assign sw_last = &sw_reg;
    assign rem_sh  = {rem_reg, num_reg[15]};

    // config register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lb_reg    <= '0;
            ub_reg    <= 16'd2560;
            decay_reg <= etm_pkg::DECAY_NONE;
            ac_reg    <= etm_pkg::ONE_Q88;
            ab_reg    <= etm_pkg::ONE_Q88;
            aw_reg    <= etm_pkg::ONE_Q88;
            pen_reg   <= '0;
            add_reg   <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                etm_pkg::REG_LB:    lb_reg    <= cfg_data[WW-1:0];
                etm_pkg::REG_UB:    ub_reg    <= cfg_data[WW-1:0];
                etm_pkg::REG_DECAY: decay_reg <= cfg_data;
                etm_pkg::REG_AC:    ac_reg    <= cfg_data[WW-1:0];
                etm_pkg::REG_AB:    ab_reg    <= cfg_data[WW-1:0];
                etm_pkg::REG_AW:    aw_reg    <= cfg_data[WW-1:0];
                etm_pkg::REG_PEN:   pen_reg   <= cfg_data[WW-1:0];
                etm_pkg::REG_ADD:   add_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        pass_next     = pass_reg;
        fill_next     = fill_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        lk_v_next     = lk_v_reg;
        lk_t_next     = lk_t_reg;
        lk_ok_next    = lk_ok_reg;
        lk_s_next     = lk_s_reg;
        ws_next       = ws_reg;
        idx_next      = idx_reg;
        sw_next       = sw_reg;
        delta_next    = delta_reg;
        max_next      = max_reg;
        last_max_next = last_max_reg;
        prod_next     = prod_reg;
        rem_next      = rem_reg;
        num_next      = num_reg;
        quo_next      = quo_reg;
        dcnt_next     = dcnt_reg;
        res_ex_next   = res_ex_reg;
        res_cnt_next  = res_cnt_reg;
        res_wt_next   = res_wt_reg;
        res_cost_next = res_cost_reg;
        mv_next       = mv_reg && !m_ready;
        o_ex_next     = o_ex_reg;
        o_cnt_next    = o_cnt_reg;
        o_wt_next     = o_wt_reg;
        o_cost_next   = o_cost_reg;
        o_max_next    = o_max_reg;

        nb_we     = 1'b0;
        cnt_we    = 1'b0;
        wt_we     = 1'b0;
        waddr     = idx_reg;
        nb_wdata  = '0;
        cnt_wdata = '0;
        wt_wdata  = etm_pkg::ONE_Q88;
        nb_raddr  = {lk_v_reg[VAW-1:0], lk_s_reg};
        c_raddr   = idx_reg;

        case (state_reg)
            etm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    from_next     = s_from_vertex;
                    to_next       = s_to_vertex;
                    res_ex_next   = 1'b0;
                    res_cnt_next  = '0;
                    res_wt_next   = '0;
                    res_cost_next = '0;
                    lk_s_next     = '0;
                    sw_next       = '0;
                    state_next    = etm_pkg::ST_DONE;
                    case (s_cmd)
                        etm_pkg::CMD_LOAD: begin
                            if (32'(s_from_vertex) < MAX_VERTICES &&
                                32'(s_to_vertex) < MAX_VERTICES &&
                                32'(s_neighbor_slot) < MAX_DEGREE) begin
                                waddr    = {s_from_vertex[VAW-1:0], SW'(s_neighbor_slot)};
                                nb_we    = 1'b1;
                                cnt_we   = 1'b1;
                                wt_we    = 1'b1;
                                nb_wdata = {1'b1, s_to_vertex};
                            end
                        end
                        etm_pkg::CMD_OPEN: begin
                            if (!add_reg && decay_reg < etm_pkg::DECAY_NONE) begin
                                pass_next  = etm_pkg::PASS_DECAY;
                                state_next = etm_pkg::ST_SW_RD;
                            end
                        end
                        etm_pkg::CMD_EVENT: begin
                            if (s_from_vertex == s_to_vertex) begin
                                if (!s_at_goal && 32'(s_from_vertex) < MAX_VERTICES) begin
                                    ws_next    = '0;
                                    state_next = etm_pkg::ST_WS_RD;
                                end
                            end else begin
                                lk_v_next  = s_from_vertex;
                                lk_t_next  = s_to_vertex;
                                lk_ok_next = 32'(s_from_vertex) < MAX_VERTICES &&
                                             32'(s_to_vertex) < MAX_VERTICES;
                                phase_next = etm_pkg::PH_FWD;
                                delta_next = add_reg ? etm_pkg::ONE_Q88 :
                                             (s_event_blocked ? ab_reg : ac_reg);
                                state_next = etm_pkg::ST_LK_RD;
                            end
                        end
                        etm_pkg::CMD_CLOSE: begin
                            pass_next  = etm_pkg::PASS_MAX;
                            max_next   = '0;
                            state_next = etm_pkg::ST_SW_RD;
                        end
                        etm_pkg::CMD_READ: begin
                            lk_v_next  = s_from_vertex;
                            lk_t_next  = s_to_vertex;
                            lk_ok_next = 32'(s_from_vertex) < MAX_VERTICES &&
                                         32'(s_to_vertex) < MAX_VERTICES;
                            phase_next = etm_pkg::PH_READ;
                            state_next = etm_pkg::ST_LK_RD;
                        end
                        etm_pkg::CMD_CLEAR: begin
                            fill_next     = etm_pkg::FILL_CLEAR;
                            last_max_next = '0;
                            state_next    = etm_pkg::ST_FILL;
                        end
                        default: ;
                    endcase
                end
            end

            // write-only sweep: reset clearing, clear counts, flat weights
            etm_pkg::ST_FILL: begin
                waddr    = sw_reg;
                wt_we    = 1'b1;
                wt_wdata = (fill_reg == etm_pkg::FILL_INIT) ? etm_pkg::ONE_Q88 : flat_w;
                cnt_we   = (fill_reg != etm_pkg::FILL_FLAT);
                nb_we    = (fill_reg == etm_pkg::FILL_INIT);
                sw_next  = sw_reg + 1'b1;
                if (sw_last) begin
                    state_next = (fill_reg == etm_pkg::FILL_INIT) ? etm_pkg::ST_IDLE
                                                                  : etm_pkg::ST_DONE;
                end
            end

            etm_pkg::ST_LK_RD: begin
                state_next = etm_pkg::ST_LK_CHK;
            end

            etm_pkg::ST_LK_CHK: begin
                if (hit) begin
                    idx_next   = {lk_v_reg[VAW-1:0], lk_s_reg};
                    state_next = etm_pkg::ST_RMW_RD;
                end else if (lk_s_reg == LAST_SLOT) begin
                    case (phase_reg)
                        etm_pkg::PH_READ: begin
                            res_wt_next   = ub_reg;
                            res_cost_next = etm_pkg::COST_INF;
                            state_next    = etm_pkg::ST_DONE;
                        end
                        etm_pkg::PH_FWD: begin
                            if (!add_reg && pen_reg != '0) begin
                                lk_v_next  = to_reg;
                                lk_t_next  = from_reg;
                                lk_s_next  = '0;
                                phase_next = etm_pkg::PH_REV;
                                delta_next = pen_reg;
                                state_next = etm_pkg::ST_LK_RD;
                            end else begin
                                state_next = etm_pkg::ST_DONE;
                            end
                        end
                        etm_pkg::PH_WAIT: begin
                            ws_next    = ws_reg + 1'b1;
                            state_next = (ws_reg == LAST_SLOT) ? etm_pkg::ST_DONE
                                                               : etm_pkg::ST_WS_RD;
                        end
                        default: state_next = etm_pkg::ST_DONE;
                    endcase
                end else begin
                    lk_s_next  = lk_s_reg + 1'b1;
                    state_next = etm_pkg::ST_LK_RD;
                end
            end

            etm_pkg::ST_RMW_RD: begin
                state_next = etm_pkg::ST_RMW_WR;
            end

            etm_pkg::ST_RMW_WR: begin
                if (phase_reg == etm_pkg::PH_READ) begin
                    res_ex_next   = 1'b1;
                    res_cnt_next  = cnt_rdata;
                    res_wt_next   = wt_rdata;
                    res_cost_next = {1'b0, etm_pkg::ONE_Q88} + {1'b0, wt_rdata};
                    state_next    = etm_pkg::ST_DONE;
                end else begin
                    cnt_we    = 1'b1;
                    cnt_wdata = etm_pkg::sat_add(cnt_rdata, delta_reg);
                    case (phase_reg)
                        etm_pkg::PH_FWD: begin
                            if (!add_reg && pen_reg != '0) begin
                                lk_v_next  = to_reg;
                                lk_t_next  = from_reg;
                                lk_s_next  = '0;
                                phase_next = etm_pkg::PH_REV;
                                delta_next = pen_reg;
                                state_next = etm_pkg::ST_LK_RD;
                            end else begin
                                state_next = etm_pkg::ST_DONE;
                            end
                        end
                        etm_pkg::PH_WAIT: begin
                            ws_next    = ws_reg + 1'b1;
                            state_next = (ws_reg == LAST_SLOT) ? etm_pkg::ST_DONE
                                                               : etm_pkg::ST_WS_RD;
                        end
                        default: state_next = etm_pkg::ST_DONE;
                    endcase
                end
            end

            // wait: scan the out-slots of the vertex
            etm_pkg::ST_WS_RD: begin
                nb_raddr   = {from_reg[VAW-1:0], ws_reg};
                state_next = etm_pkg::ST_WS_CHK;
            end

            etm_pkg::ST_WS_CHK: begin
                if (nb_rdata[TW]) begin
                    lk_v_next  = from_reg;
                    lk_t_next  = nb_rdata[TW-1:0];
                    lk_ok_next = 32'(nb_rdata[TW-1:0]) < MAX_VERTICES;
                    lk_s_next  = '0;
                    phase_next = etm_pkg::PH_WAIT;
                    delta_next = add_reg ? etm_pkg::ONE_Q88 : aw_reg;
                    state_next = etm_pkg::ST_LK_RD;
                end else begin
                    ws_next    = ws_reg + 1'b1;
                    state_next = (ws_reg == LAST_SLOT) ? etm_pkg::ST_DONE
                                                       : etm_pkg::ST_WS_RD;
                end
            end

            // count walks
            etm_pkg::ST_SW_RD: begin
                c_raddr    = sw_reg;
                state_next = etm_pkg::ST_SW_EX;
            end

            etm_pkg::ST_SW_EX: begin
                case (pass_reg)
                    etm_pkg::PASS_MAX: begin
                        if (cnt_rdata > max_reg) begin
                            max_next = cnt_rdata;
                        end
                        sw_next = sw_reg + 1'b1;
                        if (sw_last) begin
                            last_max_next = (cnt_rdata > max_reg) ? cnt_rdata : max_reg;
                            if (cnt_rdata > max_reg || max_reg != '0) begin
                                pass_next  = etm_pkg::PASS_WEIGHT;
                                state_next = etm_pkg::ST_SW_RD;
                            end else begin
                                fill_next  = etm_pkg::FILL_FLAT;
                                state_next = etm_pkg::ST_FILL;
                            end
                        end else begin
                            state_next = etm_pkg::ST_SW_RD;
                        end
                    end
                    etm_pkg::PASS_DECAY: begin
                        prod_next  = PW'(cnt_rdata) * PW'(decay_reg);
                        state_next = etm_pkg::ST_SW_WR;
                    end
                    default: begin
                        if (ub_reg <= lb_reg) begin
                            waddr    = sw_reg;
                            wt_we    = 1'b1;
                            wt_wdata = ub_reg;
                            sw_next  = sw_reg + 1'b1;
                            state_next = sw_last ? etm_pkg::ST_DONE : etm_pkg::ST_SW_RD;
                        end else begin
                            prod_next  = PW'(cnt_rdata) * PW'(ub_reg - lb_reg);
                            state_next = etm_pkg::ST_DLD;
                        end
                    end
                endcase
            end

            etm_pkg::ST_DLD: begin
                rem_next   = prod_reg[CW+15:16];
                num_next   = prod_reg[15:0];
                quo_next   = '0;
                dcnt_next  = '0;
                state_next = etm_pkg::ST_DIV;
            end

            // restoring divide by the batch maximum, one quotient bit a cycle
            etm_pkg::ST_DIV: begin
                if (rem_sh >= {1'b0, max_reg}) begin
                    rem_next = CW'(rem_sh - {1'b0, max_reg});
                    quo_next = {quo_reg[14:0], 1'b1};
                end else begin
                    rem_next = rem_sh[CW-1:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                num_next  = {num_reg[14:0], 1'b0};
                dcnt_next = dcnt_reg + 1'b1;
                if (&dcnt_reg) begin
                    state_next = etm_pkg::ST_SW_WR;
                end
            end

            etm_pkg::ST_SW_WR: begin
                waddr   = sw_reg;
                sw_next = sw_reg + 1'b1;
                if (pass_reg == etm_pkg::PASS_DECAY) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = prod_reg[CW+15:16];
                end else begin
                    wt_we    = 1'b1;
                    wt_wdata = lb_reg + quo_reg;
                end
                state_next = sw_last ? etm_pkg::ST_DONE : etm_pkg::ST_SW_RD;
            end

            // hand the result to the output register
            etm_pkg::ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next     = 1'b1;
                    o_ex_next   = res_ex_reg;
                    o_cnt_next  = res_cnt_reg;
                    o_wt_next   = res_wt_reg;
                    o_cost_next = res_cost_reg;
                    o_max_next  = last_max_reg;
                    state_next  = etm_pkg::ST_IDLE;
                end
            end

            default: state_next = etm_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= etm_pkg::ST_FILL;
            fill_reg     <= etm_pkg::FILL_INIT;
            pass_reg     <= etm_pkg::PASS_MAX;
            phase_reg    <= etm_pkg::PH_READ;
            sw_reg       <= '0;
            last_max_reg <= '0;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            pass_reg     <= pass_next;
            phase_reg    <= phase_next;
            sw_reg       <= sw_next;
            last_max_reg <= last_max_next;
            mv_reg       <= mv_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        from_reg     <= from_next;
        to_reg       <= to_next;
        lk_v_reg     <= lk_v_next;
        lk_t_reg     <= lk_t_next;
        lk_ok_reg    <= lk_ok_next;
        lk_s_reg     <= lk_s_next;
        ws_reg       <= ws_next;
        idx_reg      <= idx_next;
        delta_reg    <= delta_next;
        max_reg      <= max_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        num_reg      <= num_next;
        quo_reg      <= quo_next;
        dcnt_reg     <= dcnt_next;
        res_ex_reg   <= res_ex_next;
        res_cnt_reg  <= res_cnt_next;
        res_wt_reg   <= res_wt_next;
        res_cost_reg <= res_cost_next;
        o_ex_reg     <= o_ex_next;
        o_cnt_reg    <= o_cnt_next;
        o_wt_reg     <= o_wt_next;
        o_cost_reg   <= o_cost_next;
        o_max_reg    <= o_max_next;
    end

    // divide remainder stays below the divisor
    `ETM_ASSERT_IMP(a_div_rem, state_reg == etm_pkg::ST_DIV, rem_reg < max_reg)
    // no memory write while waiting for a command
    `ETM_ASSERT_IMP(a_idle_quiet, state_reg == etm_pkg::ST_IDLE && !s_valid,
                    !(nb_we || cnt_we || wt_we))
    // an accepted beat always leaves idle
    `ETM_ASSERT_NXT(a_accept_busy, s_valid && s_ready, state_reg != etm_pkg::ST_IDLE)

endmodule

// ===== tb/tb_edge_traffic_map.sv =====
// Self-checking testbench for the edge traffic map: directed and random command streams.
`timescale 1ns / 1ps

module tb_edge_traffic_map;

    localparam int NDEG  = etm_pkg::MAX_DEGREE_DEF;
    localparam int NSLOT = etm_pkg::MAX_VERTICES_DEF * etm_pkg::MAX_DEGREE_DEF;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    localparam logic [etm_pkg::CIW-1:0] REG_UNUSED = 4'd12;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_addr;
    logic [16:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_cmd;
    logic [9:0]  s_from_vertex;
    logic [9:0]  s_to_vertex;
    logic [1:0]  s_neighbor_slot;
    logic        s_event_blocked;
    logic        s_at_goal;
    logic        m_valid;
    logic        m_ready;
    logic        m_edge_exists;
    logic [31:0] m_traffic_cnt;
    logic [15:0] m_edge_weight;
    logic [16:0] m_path_cost;
    logic [31:0] m_peak_cnt;

    edge_traffic_map u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_from_vertex(s_from_vertex), .s_to_vertex(s_to_vertex),
        .s_neighbor_slot(s_neighbor_slot), .s_event_blocked(s_event_blocked),
        .s_at_goal(s_at_goal),
        .m_valid(m_valid), .m_ready(m_ready), .m_edge_exists(m_edge_exists),
        .m_traffic_cnt(m_traffic_cnt), .m_edge_weight(m_edge_weight),
        .m_path_cost(m_path_cost), .m_peak_cnt(m_peak_cnt)
    );

    typedef struct {
        bit        exists;
        bit [31:0] raw;
        bit [15:0] wt;
        bit [16:0] cost;
        bit [31:0] mx;
    } traffic_res_t;

    traffic_res_t pending_res[$];
    int mismatches = 0;
    int snd_idle = 0;
    int rcv_idle = 0;
    int rcv_hold = 0;
    int close_left = 0;
    int decay_left = 0;

    // Shadow copy of the edge store and registers
    bit        nb_valid[NSLOT];
    bit [9:0]  nb_tgt[NSLOT];
    bit [31:0] trf_cnt[NSLOT];
    bit [15:0] trf_wgt[NSLOT];
    bit [31:0] peak_cnt;
    bit [15:0] r_lb, r_ub, r_ac, r_ab, r_aw, r_pen;
    bit [16:0] r_decay;
    bit        r_add;

    // Clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int edge_slot(int fr, int to);
        for (int s = 0; s < NDEG; s++)
            if (nb_valid[fr*NDEG+s] && nb_tgt[fr*NDEG+s] == to)
                return fr*NDEG + s;
        return -1;
    endfunction

    function automatic void add_traffic(int fr, int to, bit [15:0] d);
        int idx;
        bit [32:0] sum;
        idx = edge_slot(fr, to);
        if (idx < 0) return;
        sum = {1'b0, trf_cnt[idx]} + {9'd0, d, 8'd0};
        trf_cnt[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic void flatten_weights();
        bit [15:0] w;
        w = (r_lb > etm_pkg::ONE_Q88) ? r_lb : etm_pkg::ONE_Q88;
        if (w > r_ub) w = r_ub;
        for (int i = 0; i < NSLOT; i++) trf_wgt[i] = w;
    endfunction

    // Applies one command to the shadow store and returns its result beat
    function automatic traffic_res_t predict_traffic(bit [2:0] cmd, int fr, int to,
                                                     int slot, bit blk, bit goal);
        traffic_res_t r;
        int idx;
        bit [63:0] prod;
        r = '{0, 0, 0, 0, 0};
        case (cmd)
            etm_pkg::CMD_LOAD: begin
                idx = fr*NDEG + slot;
                nb_valid[idx] = 1'b1;
                nb_tgt[idx] = 10'(to);
                trf_cnt[idx] = '0;
                trf_wgt[idx] = etm_pkg::ONE_Q88;
            end
            etm_pkg::CMD_OPEN: begin
                if (!r_add && r_decay < etm_pkg::DECAY_NONE)
                    for (int i = 0; i < NSLOT; i++) begin
                        prod = 64'(trf_cnt[i]) * 64'(r_decay);
                        trf_cnt[i] = prod[47:16];
                    end
            end
            etm_pkg::CMD_EVENT: begin
                if (fr == to) begin
                    // wait: spill onto every valid out-slot unless at goal
                    if (!goal)
                        for (int s = 0; s < NDEG; s++)
                            if (nb_valid[fr*NDEG+s])
                                add_traffic(fr, int'(nb_tgt[fr*NDEG+s]),
                                            r_add ? etm_pkg::ONE_Q88 : r_aw);
                end else begin
                    add_traffic(fr, to, r_add ? etm_pkg::ONE_Q88 : (blk ? r_ab : r_ac));
                    if (!r_add && r_pen != 0) add_traffic(to, fr, r_pen);
                end
            end
            etm_pkg::CMD_CLOSE: begin
                peak_cnt = '0;
                for (int i = 0; i < NSLOT; i++)
                    if (trf_cnt[i] > peak_cnt) peak_cnt = trf_cnt[i];
                if (peak_cnt == 0) flatten_weights();
                else
                    for (int i = 0; i < NSLOT; i++) begin
                        if (r_ub <= r_lb) trf_wgt[i] = r_ub;
                        else begin
                            prod = (64'(trf_cnt[i]) * 64'(r_ub - r_lb)) / 64'(peak_cnt);
                            trf_wgt[i] = r_lb + prod[15:0];
                        end
                    end
            end
            etm_pkg::CMD_READ: begin
                idx = edge_slot(fr, to);
                if (idx < 0) begin
                    r.wt = r_ub;
                    r.cost = etm_pkg::COST_INF;
                end else begin
                    r.exists = 1'b1;
                    r.raw = trf_cnt[idx];
                    r.wt = trf_wgt[idx];
                    r.cost = 17'(etm_pkg::ONE_Q88) + 17'(trf_wgt[idx]);
                end
            end
            etm_pkg::CMD_CLEAR: begin
                for (int i = 0; i < NSLOT; i++) trf_cnt[i] = '0;
                peak_cnt = '0;
                flatten_weights();
            end
            default: ;
        endcase
        r.mx = peak_cnt;
        return r;
    endfunction

    // Result checker
    always @(posedge aclk) begin
        traffic_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_res.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected", $time);
            end else begin
                e = pending_res.pop_front();
                if (m_edge_exists !== e.exists) begin
                    mismatches++;
                    $display("%0t: edge_exists exp %0d got %0d", $time, e.exists, m_edge_exists);
                end
                if (m_traffic_cnt !== e.raw) begin
                    mismatches++;
                    $display("%0t: traffic_cnt exp %h got %h", $time, e.raw, m_traffic_cnt);
                end
                if (m_edge_weight !== e.wt) begin
                    mismatches++;
                    $display("%0t: edge_weight exp %h got %h", $time, e.wt, m_edge_weight);
                end
                if (m_path_cost !== e.cost) begin
                    mismatches++;
                    $display("%0t: path_cost exp %h got %h", $time, e.cost, m_path_cost);
                end
                if (m_peak_cnt !== e.mx) begin
                    mismatches++;
                    $display("%0t: peak_cnt exp %h got %h", $time, e.mx, m_peak_cnt);
                end
            end
        end
    end

    // Receiver: random stalls plus long hold-offs counted here
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (rcv_hold > 0) begin
            rcv_hold <= rcv_hold - 1;
            m_ready <= 1'b0;
        end else m_ready <= ($urandom_range(99) >= rcv_idle);
    end

    // One command beat; valid stays up when the next beat follows at once
    task automatic send_cmd(bit [2:0] cmd, int fr, int to, int slot, bit blk, bit goal);
        if ($urandom_range(99) < snd_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < snd_idle);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_from_vertex <= 10'(fr);
        s_to_vertex <= 10'(to);
        s_neighbor_slot <= 2'(slot);
        s_event_blocked <= blk;
        s_at_goal <= goal;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_res = {pending_res, predict_traffic(cmd, fr, to, slot, blk, goal)};
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(bit [3:0] idx, bit [16:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            etm_pkg::REG_LB:    r_lb = val[15:0];
            etm_pkg::REG_UB:    r_ub = val[15:0];
            etm_pkg::REG_DECAY: r_decay = val;
            etm_pkg::REG_AC:    r_ac = val[15:0];
            etm_pkg::REG_AB:    r_ab = val[15:0];
            etm_pkg::REG_AW:    r_aw = val[15:0];
            etm_pkg::REG_PEN:   r_pen = val[15:0];
            etm_pkg::REG_ADD:   r_add = val[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(bit [15:0] lb, bit [15:0] ub, bit [16:0] dec, bit [15:0] ac,
                            bit [15:0] ab, bit [15:0] aw, bit [15:0] pen, bit add);
        drain();
        write_reg(etm_pkg::REG_LB, 17'(lb));
        write_reg(etm_pkg::REG_UB, 17'(ub));
        write_reg(etm_pkg::REG_DECAY, dec);
        write_reg(etm_pkg::REG_AC, 17'(ac));
        write_reg(etm_pkg::REG_AB, 17'(ab));
        write_reg(etm_pkg::REG_AW, 17'(aw));
        write_reg(etm_pkg::REG_PEN, 17'(pen));
        write_reg(etm_pkg::REG_ADD, 17'(add));
    endtask

    // Reset defaults, edge loads, all commands and the odd cases
    task automatic test_basic();
        send_cmd(etm_pkg::CMD_READ, 0, 1, 0, 0, 0);
        send_cmd(etm_pkg::CMD_LOAD, 0, 1, 0, 0, 0);
        send_cmd(etm_pkg::CMD_LOAD, 0, 1, 1, 0, 0);        // duplicate target
        send_cmd(etm_pkg::CMD_LOAD, 0, 2, 3, 0, 0);
        send_cmd(etm_pkg::CMD_LOAD, 1, 0, 2, 0, 0);        // reverse edge
        send_cmd(etm_pkg::CMD_LOAD, 1023, 1023, 3, 0, 0);  // self loop at the top vertex
        send_cmd(etm_pkg::CMD_LOAD, 1023, 0, 0, 0, 0);
        send_cmd(etm_pkg::CMD_EVENT, 0, 1, 0, 0, 0);
        send_cmd(etm_pkg::CMD_EVENT, 0, 1, 0, 1, 0);
        send_cmd(etm_pkg::CMD_EVENT, 0, 0, 0, 0, 0);       // wait off goal
        send_cmd(etm_pkg::CMD_EVENT, 0, 0, 0, 0, 1);       // wait at goal
        send_cmd(etm_pkg::CMD_EVENT, 1023, 1023, 0, 1, 0);
        send_cmd(etm_pkg::CMD_EVENT, 5, 6, 0, 0, 0);       // absent edge
        send_cmd(etm_pkg::CMD_OPEN, 0, 0, 0, 0, 0);
        send_cmd(etm_pkg::CMD_READ, 0, 1, 0, 0, 0);
        send_cmd(etm_pkg::CMD_CLOSE, 0, 0, 0, 0, 0);
        send_cmd(etm_pkg::CMD_READ, 0, 1, 0, 0, 0);
        send_cmd(etm_pkg::CMD_READ, 1023, 1023, 0, 0, 0);
        send_cmd(CMD_RSVD6, 1023, 1023, 3, 1, 1);
        send_cmd(CMD_RSVD7, 0, 0, 0, 0, 0);
        send_cmd(etm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
        send_cmd(etm_pkg::CMD_READ, 0, 2, 0, 0, 0);
        send_cmd(etm_pkg::CMD_READ, 2, 0, 0, 0, 0);
    endtask

    // Weighted mode: decay, contraflow, close with spread and inverted bounds
    task automatic test_weighted();
        set_regs(512, 1024, 17'd32768, 1000, 300, 77, 400, 1'b0);
        write_reg(REG_UNUSED, 17'h1FFFF);
        send_cmd(etm_pkg::CMD_EVENT, 0, 1, 0, 0, 0);
        send_cmd(etm_pkg::CMD_EVENT, 1, 0, 0, 1, 0);       // penalty onto 0->1
        send_cmd(etm_pkg::CMD_EVENT, 0, 0, 0, 0, 0);
        send_cmd(etm_pkg::CMD_OPEN, 0, 0, 0, 0, 0);
        send_cmd(etm_pkg::CMD_CLOSE, 0, 0, 0, 0, 0);
        send_cmd(etm_pkg::CMD_READ, 0, 1, 0, 0, 0);
        send_cmd(etm_pkg::CMD_READ, 0, 2, 0, 0, 0);
        send_cmd(etm_pkg::CMD_READ, 1, 0, 0, 0, 0);
        set_regs(65535, 0, 17'h1FFFF, 65535, 65535, 65535, 65535, 1'b0);
        send_cmd(etm_pkg::CMD_EVENT, 0, 1, 0, 0, 0);
        send_cmd(etm_pkg::CMD_CLOSE, 0, 0, 0, 0, 0);
        send_cmd(etm_pkg::CMD_READ, 0, 1, 0, 0, 0);
        send_cmd(etm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
        send_cmd(etm_pkg::CMD_READ, 1, 0, 0, 0, 0);
        drain();
    endtask

    // Random traffic over a small vertex set, with a few full-range ids
    task automatic test_random(int n, int vmax);
        int pick, fr, to;
        bit [2:0] cmd;
        for (int k = 0; k < n; k++) begin
            pick = int'($urandom_range(99));
            fr = ($urandom_range(15) == 0) ? int'($urandom_range(1023))
                                           : int'($urandom_range(vmax));
            to = ($urandom_range(15) == 0) ? int'($urandom_range(1023))
                                           : int'($urandom_range(vmax));
            if (pick < 15) cmd = etm_pkg::CMD_LOAD;
            else if (pick < 60) begin
                cmd = etm_pkg::CMD_EVENT;
                if ($urandom_range(2) == 0) to = fr;
            end else if (pick < 90) cmd = etm_pkg::CMD_READ;
            else if (pick < 94) cmd = etm_pkg::CMD_OPEN;
            else if (pick < 96) cmd = etm_pkg::CMD_CLOSE;
            else if (pick < 98) cmd = etm_pkg::CMD_CLEAR;
            else cmd = ($urandom_range(1) != 0) ? CMD_RSVD6 : CMD_RSVD7;
            // walks over the whole store are costly; keep them few
            if (cmd == etm_pkg::CMD_CLOSE) begin
                if (close_left > 0) close_left--;
                else cmd = etm_pkg::CMD_READ;
            end
            if (cmd == etm_pkg::CMD_OPEN && !r_add && r_decay < etm_pkg::DECAY_NONE) begin
                if (decay_left > 0) decay_left--;
                else cmd = etm_pkg::CMD_READ;
            end
            send_cmd(cmd, fr, to, int'($urandom_range(3)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        end
        drain();
    endtask

    // Long receiver hold-off while commands keep coming
    task automatic test_backpressure();
        snd_idle = 0;
        @(posedge aclk);
        rcv_hold <= 400;
        for (int k = 0; k < 40; k++)
            send_cmd(etm_pkg::CMD_READ, int'($urandom_range(7)), int'($urandom_range(7)),
                     0, 0, 0);
        drain();
    endtask

    // Watchdog
    initial begin
        #40_000_000;
        $display("tb_edge_traffic_map: errors");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_addr <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_cmd <= '0;
        s_from_vertex <= '0;
        s_to_vertex <= '0;
        s_neighbor_slot <= '0;
        s_event_blocked <= 1'b0;
        s_at_goal <= 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            nb_valid[i] = 1'b0;
            nb_tgt[i] = '0;
            trf_cnt[i] = '0;
            trf_wgt[i] = etm_pkg::ONE_Q88;
        end
        peak_cnt = '0;
        r_lb = 16'd0; r_ub = 16'd2560; r_decay = etm_pkg::DECAY_NONE;
        r_ac = 16'd256; r_ab = 16'd256; r_aw = 16'd256; r_pen = 16'd0; r_add = 1'b1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        snd_idle = 19; rcv_idle = 53;
        test_basic();
        test_weighted();

        close_left = 1; decay_left = 3;
        set_regs(0, 2560, etm_pkg::DECAY_NONE, 256, 256, 256, 0, 1'b1);
        test_random(225, 15);

        close_left = 1; decay_left = 3;
        set_regs(16'($urandom_range(1000)), 16'(1000 + $urandom_range(64535)),
                 17'($urandom_range(65535)), 16'($urandom_range(65535)),
                 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                 16'($urandom_range(65535)), 1'b0);
        test_random(225, 15);

        snd_idle = 53; rcv_idle = 19;
        close_left = 1; decay_left = 2;
        set_regs(65535, 65535, 0, 65535, 65535, 65535, 65535, 1'b0);
        test_random(225, 3);

        snd_idle = 0; rcv_idle = 0;
        close_left = 1; decay_left = 0;
        set_regs(0, 65535, 17'h1FFFF, 0, 0, 0, 0, 1'b0);
        test_random(225, 15);

        test_backpressure();

        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_res.size() == 0)
            $display("tb_edge_traffic_map: clean");
        else
            $display("tb_edge_traffic_map: errors");
        $finish;
    end
endmodule
